/* rtl/core/unc_pkg.sv */
// shared types, constants and byte-class helpers for the name cleaner
// no dependencies

package unc_pkg;

  localparam int LaDepth = 4;
  localparam logic [7:0] ChUnderscore = 8'h5F;
  localparam logic [7:0] ChSpace      = 8'h20;
  localparam logic [7:0] CaseOffset   = 8'h20;
  localparam logic [15:0] SurrLo      = 16'hD800;
  localparam logic [15:0] SurrHi      = 16'hDFFF;
  localparam logic [15:0] Utf8Lim1    = 16'h0080;
  localparam logic [15:0] Utf8Lim2    = 16'h0800;
  localparam logic [7:0] Lead2        = 8'hC0;
  localparam logic [7:0] Lead3        = 8'hE0;
  localparam logic [7:0] ContMark     = 8'h80;

  typedef enum logic [2:0] {
    S_IN,
    S_FEED,
    S_RESOLVE,
    S_APP,
    S_END
  } unc_state_t;

  typedef struct packed {
    logic take_in;
    logic feed;
    logic resolve;
    logic app;
    logic fin_pend;
    logic fin_emit;
    logic next_rq;
  } unc_cmd_t;

  typedef struct packed {
    logic can_emit;
    logic out_free;
    logic feed_append;
    logic will_fill;
    logic rq_empty;
    logic app_empty;
    logic cur_last;
    logic pend;
  } unc_stat_t;

  function automatic logic is_upper(input logic [7:0] c);
    return (c >= 8'h41) && (c <= 8'h5A);
  endfunction

  function automatic logic is_lower(input logic [7:0] c);
    return (c >= 8'h61) && (c <= 8'h7A);
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return ((c >= 8'h30) && (c <= 8'h39)) || ((c >= 8'h41) && (c <= 8'h46));
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    return (c <= 8'h39) ? c[3:0] : 4'(c[3:0] + 4'd9);
  endfunction

endpackage

/* rtl/core/unc_if.sv */
// stream channels of the name cleaner: raw bytes in, cleaned bytes out
// no dependencies

interface unc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       last_in;

  modport source (output valid, output char_in, output last_in, input ready);
  modport sink (input valid, input char_in, input last_in, output ready);
endinterface

interface unc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;
  logic       out_empty;

  modport source (output valid, output out_byte, output out_last, output out_empty,
                  input ready);
  modport sink (input valid, input out_byte, input out_last, input out_empty,
                output ready);
endinterface

/* rtl/core/unc_datapath.sv */
// datapath: lookahead, replay queue, utf-8 append buffer, held byte, output register
// depends on unc_pkg

module unc_datapath
  import unc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  unc_cmd_t   cmd,
  output unc_stat_t  stat,
  input  logic [7:0] char_in,
  input  logic       last_in,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last,
  output logic       out_empty
);

  logic [7:0] la [LaDepth];
  logic [2:0] cnt;
  logic       pend;
  logic [7:0] rq [LaDepth];
  logic [2:0] rq_n;
  logic [7:0] ab [3];
  logic [1:0] ab_n;
  logic [7:0] cur;
  logic       cur_last;
  logic [7:0] held;
  logic       hv;
  logic [1:0] lc;

  logic        out_free;
  logic        esc_ok;
  logic [15:0] cp;
  logic        plain_next;
  logic        do_space;
  logic        do_lower;
  logic        app_en;
  logic [7:0]  app_b;

  assign out_free = !out_valid || out_ready;

  // escape decode over the four lookahead bytes
  always_comb begin
    esc_ok = 1'b1;
    cp = '0;
    for (int i = 0; i < LaDepth; i++) begin
      if (!is_hex(la[i])) esc_ok = 1'b0;
      cp = {cp[11:0], hex_val(la[i])};
    end
    if (cp >= SurrLo && cp <= SurrHi) esc_ok = 1'b0;
  end

  // plain underscore: space or lowercase of held byte
  always_comb begin
    plain_next = cmd.resolve ? 1'b1 : (cnt != 3'd0);
    do_space = hv && (lc != 2'd0) && is_lower(held) && plain_next && is_upper(la[0]);
    do_lower = !do_space && (lc == 2'd2) && hv && is_upper(held);
  end

  // append source
  always_comb begin
    app_en = (cmd.feed && !pend && cur != ChUnderscore) || cmd.app;
    app_b  = cmd.app ? ab[0] : cur;
  end

  assign stat.can_emit    = !hv || out_free;
  assign stat.out_free    = out_free;
  assign stat.feed_append = !pend && cur != ChUnderscore;
  assign stat.will_fill   = pend && cnt == 3'd3;
  assign stat.rq_empty    = rq_n == 3'd0;
  assign stat.app_empty   = ab_n == 2'd0;
  assign stat.cur_last    = cur_last;
  assign stat.pend        = pend;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      pend <= 1'b0;
      rq_n <= '0;
      ab_n <= '0;
      cur_last <= 1'b0;
      held <= '0;
      hv <= 1'b0;
      lc <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (cmd.take_in) cur_last <= last_in;
      // lookahead fill and underscore start
      if (cmd.feed) begin
        if (pend) begin
          cnt <= 3'(cnt + 3'd1);
        end else if (cur == ChUnderscore) begin
          pend <= 1'b1;
          cnt <= '0;
        end
      end
      // escape or plain resolution
      if (cmd.resolve || cmd.fin_pend) begin
        pend <= 1'b0;
        cnt <= '0;
        if (cmd.resolve && esc_ok) begin
          if (cp < Utf8Lim1) ab_n <= 2'd1;
          else if (cp < Utf8Lim2) ab_n <= 2'd2;
          else ab_n <= 2'd3;
        end else begin
          rq_n <= cnt;
          ab_n <= do_space ? 2'd1 : 2'd0;
          if (do_lower) held <= 8'(held + CaseOffset);
        end
      end
      if (cmd.app) ab_n <= 2'(ab_n - 2'd1);
      if (cmd.next_rq) rq_n <= 3'(rq_n - 3'd1);
      // append: push held byte to output
      if (app_en) begin
        if (hv) out_valid <= 1'b1;
        held <= app_b;
        hv <= 1'b1;
        if (lc != 2'd2) lc <= 2'(lc + 2'd1);
      end
      if (cmd.fin_emit) begin
        out_valid <= 1'b1;
        cur_last <= 1'b0;
        held <= '0;
        hv <= 1'b0;
        lc <= '0;
        cnt <= '0;
        pend <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.take_in) cur <= char_in;
    if (cmd.next_rq) begin
      cur <= rq[0];
      for (int i = 0; i < LaDepth - 1; i++) rq[i] <= rq[i + 1];
    end
    if (cmd.feed && pend) la[cnt[1:0]] <= cur;
    if ((cmd.resolve && !esc_ok) || cmd.fin_pend) begin
      for (int i = 0; i < LaDepth; i++) rq[i] <= la[i];
      ab[0] <= ChSpace;
    end
    if (cmd.resolve && esc_ok) begin
      if (cp < Utf8Lim1) begin
        ab[0] <= cp[7:0];
      end else if (cp < Utf8Lim2) begin
        ab[0] <= Lead2 | {3'b000, cp[10:6]};
        ab[1] <= ContMark | {2'b00, cp[5:0]};
      end else begin
        ab[0] <= Lead3 | {4'h0, cp[15:12]};
        ab[1] <= ContMark | {2'b00, cp[11:6]};
        ab[2] <= ContMark | {2'b00, cp[5:0]};
      end
    end
    if (cmd.app) begin
      ab[0] <= ab[1];
      ab[1] <= ab[2];
    end
    if (app_en && hv) begin
      out_byte <= held;
      out_last <= 1'b0;
      out_empty <= 1'b0;
    end
    if (cmd.fin_emit) begin
      out_byte <= hv ? held : 8'h00;
      out_last <= 1'b1;
      out_empty <= !hv;
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (rst) cnt <= 3'd4)
    else $error("lookahead count out of range");
  a_resolve_full: assert property (@(posedge clk) disable iff (rst)
    cmd.resolve |-> (pend && cnt == 3'd4))
    else $error("resolve without full lookahead");
  a_fin_clear: assert property (@(posedge clk) disable iff (rst)
    cmd.fin_emit |=> (!hv && !pend && lc == 2'd0 && out_valid))
    else $error("name end did not clear state");

endmodule

/* rtl/core/unc_ctrl.sv */
// controller: sequences feed, resolve, append and name-end steps
// depends on unc_pkg

module unc_ctrl
  import unc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  unc_stat_t stat,
  output unc_cmd_t  cmd
);

  unc_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IN;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    case (state)
      S_IN: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take_in = 1'b1;
          state_next = S_FEED;
        end
      end
      S_FEED: begin
        if (!stat.feed_append || stat.can_emit) begin
          cmd.feed = 1'b1;
          if (stat.will_fill) state_next = S_RESOLVE;
          else if (!stat.rq_empty) cmd.next_rq = 1'b1;
          else if (stat.cur_last) state_next = S_END;
          else state_next = S_IN;
        end
      end
      S_RESOLVE: begin
        cmd.resolve = 1'b1;
        state_next = S_APP;
      end
      S_APP: begin
        if (!stat.app_empty) begin
          if (stat.can_emit) cmd.app = 1'b1;
        end else if (!stat.rq_empty) begin
          cmd.next_rq = 1'b1;
          state_next = S_FEED;
        end else if (stat.cur_last) begin
          state_next = S_END;
        end else begin
          state_next = S_IN;
        end
      end
      S_END: begin
        if (stat.pend) begin
          cmd.fin_pend = 1'b1;
          state_next = S_APP;
        end else if (stat.out_free) begin
          cmd.fin_emit = 1'b1;
          state_next = S_IN;
        end
      end
      default: state_next = S_IN;
    endcase
  end

  a_one_op: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.feed, cmd.resolve, cmd.app, cmd.fin_pend, cmd.fin_emit}))
    else $error("more than one datapath step at once");
  a_take_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.take_in |=> state == S_FEED)
    else $error("accepted byte not fed");
  a_end_last: assert property (@(posedge clk) disable iff (rst)
    cmd.fin_emit |-> stat.cur_last)
    else $error("name end without last byte");

endmodule

/* rtl/core/underscore_escape_name_cleaner_core.sv */
// top level of the underscore escape name cleaner
// depends on unc_pkg, unc_if, unc_ctrl, unc_datapath
//
//   channel | dir | payload                            | beat
//   in_ch   | in  | char_in[7:0], last_in              | one raw byte
//   out_ch  | out | out_byte[7:0], out_last, out_empty | one cleaned byte
//
// an ordinary byte is accepted and then fed; the controller runs one step
// at a time, so the step sequence sets the rate. a resolve, or an underscore
// still pending at name end, adds its resolve and queue hand-off steps, an
// append step for each utf-8 or space byte it yields and a feed step for
// each replayed byte. the name end adds a step to emit the flagged beat.
// rst is synchronous; it clears the sequencer, lookahead count and held byte.
// a full output register stalls only the steps that push a byte out.

module underscore_escape_name_cleaner_core
  import unc_pkg::*;
(
  input logic      clk,
  input logic      rst,
  unc_in_if.sink   in_ch,
  unc_out_if.source out_ch
);

  unc_cmd_t  cmd;
  unc_stat_t stat;

  unc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  unc_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .char_in   (in_ch.char_in),
    .last_in   (in_ch.last_in),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_byte  (out_ch.out_byte),
    .out_last  (out_ch.out_last),
    .out_empty (out_ch.out_empty)
  );

endmodule

/* tb/unc_tb_pkg.sv */
`timescale 1ns / 1ps
// name cleaner expectation model and result checker
// depends on unc_pkg

package unc_tb_pkg;
  import unc_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       empty;
  } clean_beat_t;

  class clean_scoreboard;
    clean_beat_t pending_q[$];
    int          errors;

    logic [7:0] la_bytes[4];
    int         la_count;
    bit         us_pend;
    logic [7:0] held;
    bit         held_ok;
    int         len_cls;

    function void clear_name();
      la_count = 0;
      us_pend  = 0;
      held     = '0;
      held_ok  = 0;
      len_cls  = 0;
      for (int i = 0; i < 4; i++) la_bytes[i] = '0;
    endfunction

    function new();
      errors = 0;
      clear_name();
    endfunction

    function void push(logic [7:0] b, bit lst, bit emp);
      clean_beat_t e;
      e.data  = b;
      e.last  = lst;
      e.empty = emp;
      pending_q.push_back(e);
    endfunction

    function void add_out(logic [7:0] b);
      if (held_ok) push(held, 0, 0);
      held    = b;
      held_ok = 1;
      if (len_cls < 2) len_cls++;
    endfunction

    function automatic bit up(logic [7:0] c);
      return c >= "A" && c <= "Z";
    endfunction

    // space between lower and upper, else drop and maybe lowercase
    function void plain_us(bit has_nx, logic [7:0] nx);
      if (held_ok && len_cls >= 1 && held >= "a" && held <= "z" && has_nx && up(nx))
        add_out(ChSpace);
      else if (len_cls >= 2 && held_ok && up(held))
        held = held + CaseOffset;
    endfunction

    function void replay();
      logic [7:0] tmp[4];
      int n;
      n = la_count;
      tmp = la_bytes;
      us_pend  = 0;
      la_count = 0;
      for (int i = 0; i < n; i++) feed_byte(tmp[i]);
    endfunction

    function void resolve4();
      bit esc;
      logic [15:0] cp;
      esc = 1;
      cp  = '0;
      for (int i = 0; i < 4; i++) begin
        if ((la_bytes[i] >= "0" && la_bytes[i] <= "9") ||
            (la_bytes[i] >= "A" && la_bytes[i] <= "F"))
          cp = {cp[11:0], (la_bytes[i] <= "9") ? la_bytes[i][3:0]
                                                : 4'(la_bytes[i][3:0] + 4'd9)};
        else
          esc = 0;
      end
      if (esc && !(cp >= 16'hD800 && cp <= 16'hDFFF)) begin
        us_pend  = 0;
        la_count = 0;
        if (cp < 16'h0080) begin
          add_out(cp[7:0]);
        end else if (cp < 16'h0800) begin
          add_out(8'hC0 | 8'(cp >> 6));
          add_out(8'h80 | {2'b0, cp[5:0]});
        end else begin
          add_out(8'hE0 | {4'b0, cp[15:12]});
          add_out(8'h80 | {2'b0, cp[11:6]});
          add_out(8'h80 | {2'b0, cp[5:0]});
        end
        return;
      end
      plain_us(1, la_bytes[0]);
      replay();
    endfunction

    function void feed_byte(logic [7:0] c);
      if (us_pend) begin
        if (la_count < 4) begin
          la_bytes[la_count] = c;
          la_count++;
        end
        if (la_count >= 4) resolve4();
      end else if (c == ChUnderscore) begin
        us_pend  = 1;
        la_count = 0;
      end else begin
        add_out(c);
      end
    endfunction

    // note one accepted input beat
    function void note_input(logic [7:0] c, bit lst);
      feed_byte(c);
      if (lst) begin
        while (us_pend) begin
          plain_us(la_count >= 1, la_bytes[0]);
          replay();
        end
        if (held_ok) push(held, 1, 0);
        else push(8'h00, 1, 1);
        clear_name();
      end
    endfunction

    // print one mismatch line and count it
    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    // compare one output beat with the oldest expectation
    task check_result(logic [7:0] b, bit lst, bit emp);
      clean_beat_t e;
      if (pending_q.size() == 0) begin
        report($sformatf("unexpected beat byte=%h last=%b empty=%b", b, lst, emp));
        return;
      end
      e = pending_q.pop_front();
      if (e.last != lst || e.empty != emp || (!e.empty && e.data != b)) begin
        report($sformatf("got byte=%h last=%b empty=%b, want byte=%h last=%b empty=%b",
                         b, lst, emp, e.data, e.last, e.empty));
      end
    endtask
  endclass
endpackage

/* tb/testbench.sv */
`timescale 1ns / 1ps
// testbench for the underscore escape name cleaner: directed and random names
// depends on unc_pkg, unc_if, unc_tb_pkg and the core rtl

module testbench;
  import unc_tb_pkg::*;

  logic clk;
  logic rst;
  int   src_idle;
  int   snk_stall;
  bit   hold_off;
  clean_scoreboard sb;

  unc_in_if  in_ch();
  unc_out_if out_ch();

  underscore_escape_name_cleaner_core dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("RESULT: ERROR");
    $finish;
  end

  // output side: random stall, long hold-off when asked
  initial begin
    out_ch.ready = 0;
    forever begin
      @(negedge clk);
      out_ch.ready <= !hold_off && ($urandom_range(99) >= snk_stall);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready)
      sb.check_result(out_ch.out_byte, out_ch.out_last, out_ch.out_empty);
  end

  // send one beat, waiting for acceptance; valid is dropped by the next
  // beat's idle phase or by drain
  task automatic send_beat(logic [7:0] c, bit lst);
    while ($urandom_range(99) < src_idle) begin
      in_ch.valid <= 0;
      @(negedge clk);
    end
    in_ch.valid   <= 1;
    in_ch.char_in <= c;
    in_ch.last_in <= lst;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_input(c, lst);
    @(negedge clk);
  endtask

  task automatic send_name(string s);
    for (int i = 0; i < s.len(); i++) send_beat(s[i], i == s.len() - 1);
  endtask

  function automatic logic [7:0] rand_char();
    string pool;
    pool = "_____0123456789ABCDEFabczGZDX";
    if ($urandom_range(9) == 0) return 8'($urandom_range(255));
    return pool[$urandom_range(pool.len() - 1)];
  endfunction

  function automatic string hex4(int v);
    return $sformatf("%04X", v);
  endfunction

  // random name built mostly from escapes and word boundaries
  task automatic send_random_name(output int n);
    string s;
    int pieces;
    s = "";
    pieces = $urandom_range(4, 1);
    for (int p = 0; p < pieces; p++) begin
      case ($urandom_range(4))
        0: s = {s, "_", hex4($urandom_range(16'hFFFF))};
        1: s = {s, "_", hex4($urandom_range(16'h07FF))};
        2: s = {s, "ab_C"};
        default: begin
          s = {s, string'(rand_char())};
          s = {s, string'(rand_char())};
        end
      endcase
    end
    n = s.len();
    send_name(s);
  endtask

  task automatic drain();
    in_ch.valid <= 0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  initial begin
    int sent;
    int n;
    sb = new();
    hold_off = 0;
    src_idle = 0;
    snk_stall = 0;
    in_ch.valid = 0;
    in_ch.char_in = '0;
    in_ch.last_in = 0;
    rst = 1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // directed: escapes, surrogate, space, lowercasing, empty, trailing underscore
    send_name("a_0041_00E9_20AC_0000");
    send_name("ab_Cd");
    send_name("AB_x");
    send_name("_D800X_");
    send_name("_");
    send_name("x_1_2");
    send_name("q_FFFF");
    send_beat(8'hFF, 0);
    send_beat(8'h00, 1);
    send_name("ab_");
    send_name("ab_C");
    drain();

    sent = 0;
    for (int ph = 0; ph < 4; ph++) begin
      src_idle  = (ph == 1 || ph == 3) ? ((ph == 3) ? 20 : 58) : 0;
      snk_stall = (ph == 2 || ph == 3) ? ((ph == 3) ? 20 : 58) : 0;
      if (ph == 2) begin
        // receiver holds off while the sender keeps offering
        fork
          begin
            hold_off = 1;
            repeat (300) @(posedge clk);
            hold_off = 0;
          end
          for (int k = 0; k < 4; k++) send_random_name(n);
        join
      end
      for (int k = 0; k < 5; k++) begin
        send_random_name(n);
        sent += n;
      end
      drain();
    end

    if (sb.errors == 0 && sb.pending_q.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end
endmodule
